FILE: rtl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared widths, codes and types of the linear-probe hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

   localparam int DEFAULT_CAPACITY = 256;
   localparam int HASH_W           = 32;
   localparam int KEY_W            = 32;
   localparam int VALUE_W          = 64;
   localparam int ACTION_W         = 2;
   localparam int STATUS_W         = 2;

   typedef enum logic [1:0] {
      TAG_EMPTY = 2'd0,
      TAG_LIVE  = 2'd1,
      TAG_TOMB  = 2'd2
   } tag_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOOKUP = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_DELETE = 2'd2
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK   = 2'd0,
      STAT_MISS = 2'd1,
      STAT_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_PROBE,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MOD_MUL,
      MOD_BACK,
      MOD_FIX
   } mod_step_type;

   typedef struct packed {
      tag_type              tag;
      logic [KEY_W-1:0]     key;
      logic [VALUE_W-1:0]   value;
      logic                 vconst;
   } slot_type;

endpackage

FILE: rtl/lpht_hash_mod.sv
// ----------------------------------------------------------------------------
// lpht_hash_mod
// Start slot unit: reduces a hash modulo the table capacity. A power-of-two
// capacity keeps the low bits of the hash; any other capacity goes through a
// multiply by a fixed reciprocal, a multiply back by the capacity and one
// correcting subtract, each registered.
// ----------------------------------------------------------------------------
module lpht_hash_mod #(
   parameter int CAPACITY = lpht_pkg::DEFAULT_CAPACITY
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [lpht_pkg::HASH_W-1:0]   hash,
   output logic                          done,
   output logic [$clog2(CAPACITY)-1:0]   slot
);
   import lpht_pkg::*;

   localparam int IDX_W   = $clog2(CAPACITY);
   localparam int SHIFT   = HASH_W + IDX_W;
   localparam int PROD_W  = 2 * HASH_W + 1;
   localparam bit IS_POW2 = (CAPACITY & (CAPACITY - 1)) == 0;
   // floor(2^SHIFT / CAPACITY) lies in [2^32, 2^33): its top bit is a shift
   localparam logic [63:0]       RECIP    = (64'd1 << SHIFT) / 64'(CAPACITY);
   localparam logic [HASH_W-1:0] RECIP_LO = RECIP[HASH_W-1:0];
   localparam logic [HASH_W-1:0] CAP_WORD = HASH_W'(CAPACITY);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   mod_step_type      step_ff, step_in;
   logic [HASH_W-1:0] hash_ff, hash_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [HASH_W-1:0] back_ff, back_in;
   logic [IDX_W-1:0]  rem_ff, rem_in;
   logic [HASH_W-1:0] quot;
   logic [HASH_W-1:0] diff;

   always_comb begin
      quot    = HASH_W'(prod_ff >> SHIFT);
      diff    = hash_ff - back_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      hash_in = hash_ff;
      prod_in = prod_ff;
      back_in = back_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         hash_in = hash;
         step_in = MOD_MUL;
      end else if (busy_ff) begin
         if (IS_POW2) begin
            rem_in  = hash_ff[IDX_W-1:0];
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            unique case (step_ff)
               MOD_MUL: begin
                  // estimate the quotient; it falls short by at most one
                  prod_in = {1'b0, hash_ff, {HASH_W{1'b0}}} +
                            PROD_W'(hash_ff) * PROD_W'(RECIP_LO);
                  step_in = MOD_BACK;
               end
               MOD_BACK: begin
                  back_in = quot * CAP_WORD;
                  step_in = MOD_FIX;
               end
               default: begin
                  rem_in  = (diff >= CAP_WORD) ? IDX_W'(diff - CAP_WORD) : IDX_W'(diff);
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      hash_ff <= hash_in;
      prod_ff <= prod_in;
      back_ff <= back_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign slot = rem_ff;

endmodule

FILE: rtl/linear_probe_hash_table_top.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top
// Fixed-capacity open-addressing map with linear probing and tombstones.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot memory, one slot a cycle, marking
// every slot empty; no request is taken until the sweep ends. A request is
// then accepted and registered, and the remainder unit finds the start slot
// (for a power-of-two CAPACITY it keeps the low bits of the hash; otherwise
// it multiplies by a fixed reciprocal, multiplies back, corrects once and
// hands over). The probe then reads the slots in turn, since the slot memory
// has one read port and a registered read. The result word is handed over and
// the slot written back once the output register is free. Lookups and deletes
// on a table whose slots are all still empty, refused inserts and unknown
// actions skip the probe and go straight to the hand-over. A new request is
// taken while the previous result still waits in the output register.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top #(
   parameter int CAPACITY = lpht_pkg::DEFAULT_CAPACITY
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [lpht_pkg::ACTION_W-1:0]  req_action,
   input  logic [lpht_pkg::KEY_W-1:0]     req_key_id,
   input  logic [lpht_pkg::HASH_W-1:0]    req_key_hash,
   input  logic [lpht_pkg::VALUE_W-1:0]   req_value_word,
   input  logic                           req_value_const,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [lpht_pkg::STATUS_W-1:0]  rsp_status,
   output logic                           rsp_new_key,
   output logic [lpht_pkg::VALUE_W-1:0]   rsp_found_value,
   output logic                           rsp_found_const
);
   import lpht_pkg::*;

   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int LOAD_W     = CNT_W + 3;
   localparam int LOAD_LIMIT = 3 * CAPACITY;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [IDX_W-1:0]     steps_ff, steps_in;
   logic [IDX_W-1:0]     tomb_ff, tomb_in;
   logic                 have_tomb_ff, have_tomb_in;
   logic [CNT_W-1:0]     used_ff, used_in;

   action_type           action_ff, action_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [VALUE_W-1:0]   value_ff, value_in;
   logic                 vconst_ff, vconst_in;

   status_type           res_status_ff, res_status_in;
   logic                 res_newk_ff, res_newk_in;
   logic [VALUE_W-1:0]   res_fval_ff, res_fval_in;
   logic                 res_fconst_ff, res_fconst_in;
   logic                 wr_pend_ff, wr_pend_in;
   logic [IDX_W-1:0]     wr_addr_ff, wr_addr_in;
   slot_type             wr_entry_ff, wr_entry_in;
   logic                 used_inc_ff, used_inc_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic                 rsp_newk_ff, rsp_newk_in;
   logic [VALUE_W-1:0]   rsp_fval_ff, rsp_fval_in;
   logic                 rsp_fconst_ff, rsp_fconst_in;

   slot_type             slot_mem [CAPACITY];
   slot_type             rd_entry_ff;
   logic                 mem_wr_en;
   logic [IDX_W-1:0]     mem_wr_addr;
   slot_type             mem_wr_data;

   logic                 mod_start;
   logic                 mod_done;
   logic [IDX_W-1:0]     mod_slot;

   logic [LOAD_W-1:0]    load_lhs;
   logic                 load_full;
   logic                 hit, empty, last, tomb_now, have_t, has_place, finish;
   logic [IDX_W-1:0]     tomb_idx, idx_next;

   lpht_hash_mod #(
      .CAPACITY (CAPACITY)
   ) u_hash_mod (
      .clock (clock),
      .reset (reset),
      .start (mod_start),
      .hash  (req_key_hash),
      .done  (mod_done),
      .slot  (mod_slot)
   );

   always_comb begin
      load_lhs  = {1'b0, used_ff, 2'b00} + LOAD_W'(4);
      load_full = load_lhs > LOAD_W'(LOAD_LIMIT);

      hit       = (rd_entry_ff.tag == TAG_LIVE) && (rd_entry_ff.key == key_ff);
      empty     = rd_entry_ff.tag == TAG_EMPTY;
      last      = steps_ff == IDX_W'(CAPACITY - 1);
      tomb_now  = (rd_entry_ff.tag == TAG_TOMB) && !have_tomb_ff;
      have_t    = have_tomb_ff || tomb_now;
      tomb_idx  = have_tomb_ff ? tomb_ff : idx_ff;
      has_place = hit || empty || have_t;
      finish    = hit || empty || last;
      idx_next  = (idx_ff == IDX_W'(CAPACITY - 1)) ? '0 : idx_ff + IDX_W'(1);

      state_in      = state_ff;
      idx_in        = idx_ff;
      steps_in      = steps_ff;
      tomb_in       = tomb_ff;
      have_tomb_in  = have_tomb_ff;
      used_in       = used_ff;
      action_in     = action_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      vconst_in     = vconst_ff;
      res_status_in = res_status_ff;
      res_newk_in   = res_newk_ff;
      res_fval_in   = res_fval_ff;
      res_fconst_in = res_fconst_ff;
      wr_pend_in    = wr_pend_ff;
      wr_addr_in    = wr_addr_ff;
      wr_entry_in   = wr_entry_ff;
      used_inc_in   = used_inc_ff;
      rsp_status_in = rsp_status_ff;
      rsp_newk_in   = rsp_newk_ff;
      rsp_fval_in   = rsp_fval_ff;
      rsp_fconst_in = rsp_fconst_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      req_ready     = 1'b0;
      mod_start     = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = wr_addr_ff;
      mem_wr_data   = wr_entry_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en       = 1'b1;
            mem_wr_addr     = idx_ff;
            mem_wr_data     = '0;
            mem_wr_data.tag = TAG_EMPTY;
            idx_in          = idx_next;
            if (idx_ff == IDX_W'(CAPACITY - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               action_in     = action_type'(req_action);
               key_in        = req_key_id;
               value_in      = req_value_word;
               vconst_in     = req_value_const;
               res_status_in = STAT_MISS;
               res_newk_in   = 1'b0;
               res_fval_in   = '0;
               res_fconst_in = 1'b0;
               wr_pend_in    = 1'b0;
               used_inc_in   = 1'b0;
               priority if ((action_type'(req_action) == ACT_LOOKUP) ||
                            (action_type'(req_action) == ACT_DELETE)) begin
                  if (used_ff == '0) begin
                     state_in = ST_DONE;
                  end else begin
                     mod_start = 1'b1;
                     state_in  = ST_MOD;
                  end
               end else if (action_type'(req_action) == ACT_INSERT) begin
                  if (load_full) begin
                     res_status_in = STAT_FULL;
                     state_in      = ST_DONE;
                  end else begin
                     mod_start = 1'b1;
                     state_in  = ST_MOD;
                  end
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               idx_in       = mod_slot;
               steps_in     = '0;
               have_tomb_in = 1'b0;
               state_in     = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (!finish) begin
               // step on to the next slot; its read is issued this cycle
               idx_in       = idx_next;
               steps_in     = steps_ff + IDX_W'(1);
               have_tomb_in = have_t;
               tomb_in      = tomb_idx;
            end else begin
               state_in = ST_DONE;
               unique case (action_ff)
                  ACT_LOOKUP: begin
                     if (hit) begin
                        res_status_in = STAT_OK;
                        res_fval_in   = rd_entry_ff.value;
                        res_fconst_in = rd_entry_ff.vconst;
                     end
                  end
                  ACT_INSERT: begin
                     if (has_place) begin
                        res_status_in      = STAT_OK;
                        res_newk_in        = !hit;
                        wr_pend_in         = 1'b1;
                        wr_addr_in         = (!hit && have_t) ? tomb_idx : idx_ff;
                        wr_entry_in.tag    = TAG_LIVE;
                        wr_entry_in.key    = key_ff;
                        wr_entry_in.value  = value_ff;
                        wr_entry_in.vconst = vconst_ff;
                        used_inc_in        = !hit && !have_t;
                     end else begin
                        res_status_in = STAT_FULL;
                     end
                  end
                  ACT_DELETE: begin
                     if (hit) begin
                        res_status_in   = STAT_OK;
                        wr_pend_in      = 1'b1;
                        wr_addr_in      = idx_ff;
                        wr_entry_in     = rd_entry_ff;
                        wr_entry_in.tag = TAG_TOMB;
                     end
                  end
                  default: begin
                     res_status_in = STAT_MISS;
                  end
               endcase
            end
         end
         ST_DONE: begin
            // hold until the output register is free, then commit
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_newk_in   = res_newk_ff;
               rsp_fval_in   = res_fval_ff;
               rsp_fconst_in = res_fconst_ff;
               mem_wr_en     = wr_pend_ff;
               if (used_inc_ff) begin
                  used_in = used_ff + CNT_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         slot_mem[mem_wr_addr] <= mem_wr_data;
      end
      rd_entry_ff <= slot_mem[idx_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         wr_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         wr_pend_ff   <= wr_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      steps_ff      <= steps_in;
      tomb_ff       <= tomb_in;
      have_tomb_ff  <= have_tomb_in;
      action_ff     <= action_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      vconst_ff     <= vconst_in;
      res_status_ff <= res_status_in;
      res_newk_ff   <= res_newk_in;
      res_fval_ff   <= res_fval_in;
      res_fconst_ff <= res_fconst_in;
      wr_addr_ff    <= wr_addr_in;
      wr_entry_ff   <= wr_entry_in;
      used_inc_ff   <= used_inc_in;
      rsp_status_ff <= rsp_status_in;
      rsp_newk_ff   <= rsp_newk_in;
      rsp_fval_ff   <= rsp_fval_in;
      rsp_fconst_ff <= rsp_fconst_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_new_key     = rsp_newk_ff;
   assign rsp_found_value = rsp_fval_ff;
   assign rsp_found_const = rsp_fconst_ff;

endmodule
